[hdl/umds_pkg.sv]
// Shared types and constants for the USB mass-storage descriptor scanner.
// Used by umds_cfg, umds_walker and usb_msc_descriptor_scanner; no dependencies.
package umds_pkg;

    localparam int BYTE_W     = 8;
    localparam int FIELD_N    = 6;
    localparam int FIELD_IDX_W = 3;
    localparam int OUT_TDATA_W = 56;

    // Configuration register indexes.
    localparam logic [1:0] CFG_CLASS    = 2'd0;
    localparam logic [1:0] CFG_SUBCLASS = 2'd1;
    localparam logic [1:0] CFG_PROTOCOL = 2'd2;

    localparam logic [7:0] RST_CLASS    = 8'h08;
    localparam logic [7:0] RST_SUBCLASS = 8'h06;
    localparam logic [7:0] RST_PROTOCOL = 8'h50;

    localparam logic [7:0] DESC_INTERFACE = 8'h04;
    localparam logic [7:0] DESC_ENDPOINT  = 8'h05;
    localparam logic [7:0] IFACE_MIN_LEN  = 8'd9;
    localparam logic [7:0] EP_MIN_LEN     = 8'd7;
    localparam logic [1:0] XFER_BULK      = 2'b10;
    localparam int         EP_DIR_BIT     = 7;

    typedef enum logic [1:0] {
        PH_SEARCH    = 2'd0,
        PH_SCAN      = 2'd1,
        PH_END_MATCH = 2'd2,
        PH_END_NONE  = 2'd3
    } t_phase;

    typedef enum logic [1:0] {
        ST_FOUND    = 2'd0,
        ST_NO_IFACE = 2'd1,
        ST_NO_EP    = 2'd2
    } t_status;

    typedef struct packed {
        logic [7:0] cls;
        logic [7:0] subcls;
        logic [7:0] proto;
    } t_match;

    typedef struct packed {
        logic [15:0] out_mps;
        logic [15:0] in_mps;
        logic [3:0]  out_ep;
        logic [3:0]  in_ep;
        logic [7:0]  iface;
        t_status     status;
    } t_result;

endpackage

[hdl/umds_cfg.sv]
// Match-code registers for the descriptor scanner, written through the config channel.
// Depends on umds_pkg.
module umds_cfg import umds_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_valid,
    input  logic [1:0]  i_cfg_index,
    input  logic [7:0]  i_cfg_data,
    output t_match      o_match
);

    t_match r_match;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_match.cls    <= RST_CLASS;
            r_match.subcls <= RST_SUBCLASS;
            r_match.proto  <= RST_PROTOCOL;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_CLASS:    r_match.cls    <= i_cfg_data;
                CFG_SUBCLASS: r_match.subcls <= i_cfg_data;
                CFG_PROTOCOL: r_match.proto  <= i_cfg_data;
                default: ;
            endcase
        end
    end

    assign o_match = r_match;

endmodule

[hdl/umds_walker.sv]
// Descriptor walk state: length/type tracking, interface match and bulk endpoint capture.
// Depends on umds_pkg.
module umds_walker import umds_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    input  logic [7:0] i_byte,
    input  logic       i_last,
    input  t_match     i_match,
    output t_result    o_result
);

    logic [7:0]  r_pos, n_pos;
    logic [7:0]  r_len, n_len;
    logic [7:0]  r_kind, n_kind;
    t_phase      r_phase, n_phase;
    logic [7:0]  r_iface, n_iface;
    logic [3:0]  r_in_ep, n_in_ep;
    logic [3:0]  r_out_ep, n_out_ep;
    logic [15:0] r_in_mps, n_in_mps;
    logic [15:0] r_out_mps, n_out_mps;
    logic [7:0]  r_field [FIELD_N];

    logic                   field_we;
    logic [FIELD_IDX_W-1:0] field_idx;
    logic                   desc_end;
    logic                   iface_hit;
    logic                   bulk_ep;

    assign field_idx = FIELD_IDX_W'(r_pos - 8'd2);
    assign desc_end  = ({1'b0, r_pos} + 9'd1) >= {1'b0, r_len};
    assign iface_hit = (r_kind == DESC_INTERFACE) && (r_len >= IFACE_MIN_LEN) &&
                       (r_field[3] == i_match.cls) && (r_field[4] == i_match.subcls) &&
                       (r_field[5] == i_match.proto);
    assign bulk_ep   = (r_kind == DESC_ENDPOINT) && (r_len >= EP_MIN_LEN) &&
                       (r_field[1][1:0] == XFER_BULK);

    // Next-state logic: one byte of the walk, then a full clear after the last byte.
    always_comb begin
        n_pos     = r_pos;
        n_len     = r_len;
        n_kind    = r_kind;
        n_phase   = r_phase;
        n_iface   = r_iface;
        n_in_ep   = r_in_ep;
        n_out_ep  = r_out_ep;
        n_in_mps  = r_in_mps;
        n_out_mps = r_out_mps;
        field_we  = 1'b0;
        if (i_valid && (r_phase == PH_SEARCH || r_phase == PH_SCAN)) begin
            if (r_pos == 8'd0) begin
                n_len  = i_byte;
                n_kind = 8'd0;
                if (i_byte == 8'd0) begin
                    n_phase = (r_phase == PH_SCAN) ? PH_END_MATCH : PH_END_NONE;
                end else if (i_byte != 8'd1) begin
                    n_pos = 8'd1;
                end
            end else if (r_pos == 8'd1 && r_phase == PH_SCAN && i_byte == DESC_INTERFACE) begin
                // Any following interface descriptor closes the endpoint scan at once.
                n_kind  = i_byte;
                n_phase = PH_END_MATCH;
            end else begin
                if (r_pos == 8'd1) begin
                    n_kind = i_byte;
                end else if (r_pos <= 8'd7) begin
                    field_we = 1'b1;
                end
                if (desc_end) begin
                    n_pos = 8'd0;
                    // Short descriptors never pass the length checks, so only
                    // field bytes of the current descriptor are looked at here.
                    if (r_phase == PH_SEARCH) begin
                        if (iface_hit) begin
                            n_phase   = PH_SCAN;
                            n_iface   = r_field[0];
                            n_in_ep   = 4'd0;
                            n_out_ep  = 4'd0;
                            n_in_mps  = 16'd0;
                            n_out_mps = 16'd0;
                        end
                    end else if (bulk_ep) begin
                        if (r_field[0][EP_DIR_BIT]) begin
                            n_in_ep  = r_field[0][3:0];
                            n_in_mps = {r_field[3], r_field[2]};
                        end else begin
                            n_out_ep  = r_field[0][3:0];
                            n_out_mps = {r_field[3], r_field[2]};
                        end
                    end
                end else begin
                    n_pos = r_pos + 8'd1;
                end
            end
        end
    end

    // Result of the block, taken from the state after the final byte.
    always_comb begin
        if (n_phase == PH_SCAN || n_phase == PH_END_MATCH) begin
            o_result.status  = (n_in_ep != 4'd0 && n_out_ep != 4'd0) ? ST_FOUND : ST_NO_EP;
            o_result.iface   = n_iface;
            o_result.in_ep   = n_in_ep;
            o_result.out_ep  = n_out_ep;
            o_result.in_mps  = n_in_mps;
            o_result.out_mps = n_out_mps;
        end else begin
            o_result.status  = ST_NO_IFACE;
            o_result.iface   = 8'd0;
            o_result.in_ep   = 4'd0;
            o_result.out_ep  = 4'd0;
            o_result.in_mps  = 16'd0;
            o_result.out_mps = 16'd0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || (i_valid && i_last)) begin
            r_pos     <= 8'd0;
            r_len     <= 8'd0;
            r_kind    <= 8'd0;
            r_phase   <= PH_SEARCH;
            r_iface   <= 8'd0;
            r_in_ep   <= 4'd0;
            r_out_ep  <= 4'd0;
            r_in_mps  <= 16'd0;
            r_out_mps <= 16'd0;
        end else begin
            r_pos     <= n_pos;
            r_len     <= n_len;
            r_kind    <= n_kind;
            r_phase   <= n_phase;
            r_iface   <= n_iface;
            r_in_ep   <= n_in_ep;
            r_out_ep  <= n_out_ep;
            r_in_mps  <= n_in_mps;
            r_out_mps <= n_out_mps;
        end
    end

    always_ff @(posedge i_clk) begin
        if (field_we) begin
            r_field[field_idx] <= i_byte;
        end
    end

`ifndef ASSERT_OFF
    a_clear_after_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && i_last |=> r_phase == PH_SEARCH && r_pos == 8'd0)
        else $error("walk state not cleared after the last item");

    a_pos_in_desc: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_SEARCH || r_phase == PH_SCAN) && r_pos != 8'd0 |-> r_pos < r_len)
        else $error("byte position ran past the descriptor length");

    a_no_ep_while_search: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_phase == PH_SEARCH |-> r_in_ep == 4'd0 && r_out_ep == 4'd0)
        else $error("endpoint recorded before an interface matched");
`endif

endmodule

[hdl/usb_msc_descriptor_scanner.sv]
// Top level of the USB mass-storage descriptor scanner: input register, walker, result register.
// Depends on umds_pkg, umds_cfg and umds_walker.
//
// Usage:
//   s_axis carries the configuration descriptor block, one byte per item, with
//   tlast on the final byte. m_axis gives one result item per block, on the
//   final byte: status, interface number and bulk IN/OUT endpoints with their
//   max packet sizes. The config channel (i_cfg_*) sets the class, subclass and
//   protocol to match; it is always ready; the user must write it only while idle (not enforced).
//   Throughput is one byte per cycle: the input register feeds the walker,
//   whose compare-and-count logic is combinational into the registered walk state.
//   The final byte passes the input register, then the result register (m_axis_tvalid).
//   When m_axis is stalled, non-final bytes keep flowing; a final byte waits in
//   the input register until the result register is free, and s_axis_tready
//   drops only then. Reset clears the walk, the pending items and restores the
//   match codes to mass storage, SCSI transparent, bulk-only transport.
//   After each result the walk starts afresh for the next block.
module usb_msc_descriptor_scanner import umds_pkg::*; (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    input  logic [7:0]             s_axis_tdata,   // [7:0] desc_byte
    input  logic                   s_axis_tlast,   // is_last
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    // [1:0] scan_status, [9:2] iface_number, [13:10] in_endpoint,
    // [17:14] out_endpoint, [33:18] in_max_packet, [49:34] out_max_packet
    output logic [OUT_TDATA_W-1:0] m_axis_tdata,
    input  logic                   i_cfg_valid,
    output logic                   o_cfg_ready,
    input  logic [1:0]             i_cfg_index,
    input  logic [7:0]             i_cfg_data
);

    logic       r_in_valid;
    logic [7:0] r_in_byte;
    logic       r_in_last;
    logic       r_out_valid;
    t_result    r_out;
    t_result    walk_result;
    t_match     match;
    logic       out_free;
    logic       advance;

    assign out_free      = !r_out_valid || m_axis_tready;
    assign advance       = r_in_valid && (!r_in_last || out_free);
    assign s_axis_tready = !r_in_valid || advance;
    assign o_cfg_ready   = 1'b1;

    umds_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_match     (match)
    );

    umds_walker u_walker (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (advance),
        .i_byte   (r_in_byte),
        .i_last   (r_in_last),
        .i_match  (match),
        .o_result (walk_result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_axis_tready) begin
            r_in_valid <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tready && s_axis_tvalid) begin
            r_in_byte <= s_axis_tdata;
            r_in_last <= s_axis_tlast;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance && r_in_last) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance && r_in_last) begin
            r_out <= walk_result;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {{(OUT_TDATA_W - $bits(t_result)){1'b0}}, r_out};

`ifndef ASSERT_OFF
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && !m_axis_tready |-> !(advance && r_in_last))
        else $error("pending result overwritten");

    a_result_follows_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        advance && r_in_last |=> r_out_valid)
        else $error("final item gave no result");

    a_status_legal: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> r_out.status == ST_FOUND || r_out.status == ST_NO_IFACE ||
                        r_out.status == ST_NO_EP)
        else $error("illegal status code in result");
`endif

endmodule
